// File: rtl/kwm_pkg.sv
// Shared widths, defaults and types for the timestamp merge block.
package kwm_pkg;

	localparam int SRC_W           = 4;
	localparam int KEY_W           = 64;
	localparam int DATA_W          = 64;
	localparam int CNT_W           = 5;
	localparam int SOURCE_SPAN     = 16;
	localparam int MAX_SOURCES_DEF = 16;

	// Head slot update, applied at the edge an item leaves the input stage or a count is written.
	typedef struct packed {
		logic              insert;    // store record as head of src
		logic              mark_end;  // src has ended
		logic              pop;       // free the head of pop_src
		logic              clear;     // drop every head and end mark
		logic [SRC_W-1:0]  src;
		logic [SRC_W-1:0]  pop_src;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} slot_upd_t;

	// Winner of the minimum search.
	typedef struct packed {
		logic              valid;
		logic [SRC_W-1:0]  idx;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} best_t;

endpackage

// File: rtl/kwm_slots.sv
// Per-source head registers with full and ended flags.
module kwm_slots #(
	parameter int NSRC = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kwm_pkg::slot_upd_t        upd,
	output logic [kwm_pkg::KEY_W-1:0] head_key [NSRC],
	output logic [kwm_pkg::DATA_W-1:0] head_data [NSRC],
	output logic [NSRC-1:0]           head_full,
	output logic [NSRC-1:0]           source_ended
);
	import kwm_pkg::*;

	logic [KEY_W-1:0]  key_q  [NSRC];
	logic [DATA_W-1:0] data_q [NSRC];
	logic [NSRC-1:0]   full_q;
	logic [NSRC-1:0]   ended_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= '0;
			ended_q <= '0;
		end else begin
			for (int i = 0; i < NSRC; i++) begin
				if (upd.clear) begin
					full_q[i]  <= 1'b0;
					ended_q[i] <= 1'b0;
				end else begin
					// pop wins: a new record may be taken at once
					if (upd.pop && upd.pop_src == SRC_W'(i))
						full_q[i] <= 1'b0;
					else if (upd.insert && upd.src == SRC_W'(i))
						full_q[i] <= 1'b1;
					if (upd.mark_end && upd.src == SRC_W'(i))
						ended_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NSRC; i++) begin
			if (upd.insert && upd.src == SRC_W'(i)) begin
				key_q[i]  <= upd.key;
				data_q[i] <= upd.data;
			end
		end
	end

	assign head_key     = key_q;
	assign head_data    = data_q;
	assign head_full    = full_q;
	assign source_ended = ended_q;

endmodule

// File: rtl/kwm_min_tree.sv
// Comparator tree: smallest valid key, lower lane wins ties.
module kwm_min_tree #(
	parameter int N = 16
) (
	input  logic [N-1:0]               lane_valid,
	input  logic [kwm_pkg::KEY_W-1:0]  lane_key  [N],
	input  logic [kwm_pkg::DATA_W-1:0] lane_data [N],
	output kwm_pkg::best_t             best
);
	import kwm_pkg::*;

	localparam int P     = 1 << $clog2(N);
	localparam int NODES = 2 * P - 1;

	best_t node [NODES];

	always_comb begin
		logic take_r;
		take_r = 1'b0;
		for (int i = 0; i < P; i++) begin
			if (i < N) begin
				node[P-1+i].valid = lane_valid[i];
				node[P-1+i].idx   = SRC_W'(i);
				node[P-1+i].key   = lane_key[i];
				node[P-1+i].data  = lane_data[i];
			end else begin
				node[P-1+i] = '0;
			end
		end
		// left child holds the lower lanes
		for (int k = P - 2; k >= 0; k--) begin
			take_r = node[2*k+2].valid &&
				(!node[2*k+1].valid || node[2*k+2].key < node[2*k+1].key);
			node[k] = take_r ? node[2*k+2] : node[2*k+1];
		end
	end

	assign best = node[0];

endmodule

// File: rtl/kway_timestamp_merge.sv
// Top level of the k-way timestamp merge.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | sink      | in_valid/in_stall   | in_source, in_timestamp, in_payload, in_end
//  out     | source    | out_valid/out_stall | out_timestamp, out_source, out_payload,
//          |           |                     | out_last, out_rejected
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_data (source count)
//
// One item per cycle while in_stall is low. An item is registered in the
// input stage, checked and merged there by the slot logic and the comparator
// tree, and its result (if any) is registered in the output register.
// The 16-way 64-bit comparator tree sets the cycle time.
// Reset clears all flags, sets the source count to its maximum, no item held.
// in_stall rises only when the input stage holds an item that has a result
// while the output register is full and stalled; items with no result drain.
// cfg_ready is high when no item is held in either register.
module kway_timestamp_merge #(
	parameter int MAX_SOURCES = kwm_pkg::MAX_SOURCES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [kwm_pkg::SRC_W-1:0]  in_source,
	input  logic [kwm_pkg::KEY_W-1:0]  in_timestamp,
	input  logic [kwm_pkg::DATA_W-1:0] in_payload,
	input  logic                       in_end,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [kwm_pkg::KEY_W-1:0]  out_timestamp,
	output logic [kwm_pkg::SRC_W-1:0]  out_source,
	output logic [kwm_pkg::DATA_W-1:0] out_payload,
	output logic                       out_last,
	output logic                       out_rejected,
	// source count register
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kwm_pkg::CNT_W-1:0]  cfg_data
);
	import kwm_pkg::*;

	// usable sources: bounded by the 4-bit source field
	localparam int NSRC = (MAX_SOURCES < SOURCE_SPAN) ? MAX_SOURCES : SOURCE_SPAN;

	// ---- configuration: clamped count kept in a register
	logic [CNT_W-1:0] active_q;
	logic [CNT_W-1:0] cfg_cnt;
	logic             cfg_wr;

	always_comb begin
		if (cfg_data == '0)
			cfg_cnt = CNT_W'(1);
		else if (cfg_data > CNT_W'(NSRC))
			cfg_cnt = CNT_W'(NSRC);
		else
			cfg_cnt = cfg_data;
	end

	// ---- input stage
	logic              valid_s1;
	logic [SRC_W-1:0]  source_s1;
	logic [KEY_W-1:0]  ts_s1;
	logic [DATA_W-1:0] pay_s1;
	logic              end_s1;

	logic in_take;
	logic advance;

	// ---- slot state
	slot_upd_t         upd;
	logic [KEY_W-1:0]  head_key  [NSRC];
	logic [DATA_W-1:0] head_data [NSRC];
	logic [NSRC-1:0]   head_full;
	logic [NSRC-1:0]   source_ended;

	kwm_slots #(
		.NSRC(NSRC)
	) u_slots (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (upd),
		.head_key     (head_key),
		.head_data    (head_data),
		.head_full    (head_full),
		.source_ended (source_ended)
	);

	// ---- per-lane view after this item is applied
	logic [NSRC-1:0]   hit;       // lane addressed by the item
	logic [NSRC-1:0]   act;       // lane below the active count
	logic [NSRC-1:0]   ins_hit;   // lane takes the new record
	logic [NSRC-1:0]   full_n;
	logic [NSRC-1:0]   ended_n;
	logic [KEY_W-1:0]  lane_key  [NSRC];
	logic [DATA_W-1:0] lane_data [NSRC];
	logic              reject;
	logic              waiting;
	logic              any_head;
	logic              emit;
	logic              done;
	logic              has_res;
	best_t             best;

	always_comb begin
		for (int i = 0; i < NSRC; i++) begin
			hit[i] = (source_s1 == SRC_W'(i));
			act[i] = (CNT_W'(i) < active_q);
		end
		// out of range, slot already full, or source already ended
		reject  = ({1'b0, source_s1} >= active_q) ||
			(|(hit & (head_full | source_ended)));
		ins_hit = hit & {NSRC{!end_s1 && !reject}};
		full_n  = head_full | ins_hit;
		ended_n = source_ended | (hit & {NSRC{end_s1 && !reject}});
		for (int i = 0; i < NSRC; i++) begin
			lane_key[i]  = ins_hit[i] ? ts_s1  : head_key[i];
			lane_data[i] = ins_hit[i] ? pay_s1 : head_data[i];
		end
		waiting  = |(act & ~full_n & ~ended_n);
		any_head = |(act & full_n);
		emit     = !reject && !waiting && any_head;
		done     = !reject && !waiting && !any_head;
		has_res  = reject || !waiting;
	end

	kwm_min_tree #(
		.N(NSRC)
	) u_tree (
		.lane_valid (act & full_n),
		.lane_key   (lane_key),
		.lane_data  (lane_data),
		.best       (best)
	);

	// ---- handshakes
	// item leaves the input stage unless its result would hit a stalled output
	assign advance   = valid_s1 && (!has_res || !out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = !valid_s1 && !out_valid;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		upd          = '0;
		upd.src      = source_s1;
		upd.pop_src  = best.idx;
		upd.key      = ts_s1;
		upd.data     = pay_s1;
		upd.insert   = advance && !reject && !end_s1;
		upd.mark_end = advance && !reject && end_s1;
		upd.pop      = advance && emit;
		upd.clear    = (advance && done) || cfg_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(NSRC);
		end else if (cfg_wr) begin
			active_q <= cfg_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			source_s1 <= in_source;
			ts_s1     <= in_timestamp;
			pay_s1    <= in_payload;
			end_s1    <= in_end;
		end
	end

	// ---- result register
	logic              out_valid_q;
	logic [KEY_W-1:0]  out_ts_q;
	logic [SRC_W-1:0]  out_src_q;
	logic [DATA_W-1:0] out_pay_q;
	logic              out_last_q;
	logic              out_rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_ts_q   <= emit ? best.key  : '0;
			out_src_q  <= emit ? best.idx  : '0;
			out_pay_q  <= emit ? best.data : '0;
			out_last_q <= done;
			out_rej_q  <= reject;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_timestamp = out_ts_q;
	assign out_source    = out_src_q;
	assign out_payload   = out_pay_q;
	assign out_last      = out_last_q;
	assign out_rejected  = out_rej_q;

	// ---- checks
	// a source never holds a head after its end mark
	a_full_xor_ended: assert property (@(posedge clk) disable iff (!arst_n)
		(head_full & source_ended) == '0)
		else $error("source both full and ended");

	// a count write abandons the merge
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (head_full == '0) && (source_ended == '0))
		else $error("flags left after count write");

	// completion leaves nothing behind
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && done) |=> (head_full == '0) && (source_ended == '0))
		else $error("flags left after completion");

	// a stall upstream only while the input stage holds a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && has_res && out_valid && out_stall))
		else $error("input stalled without cause");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the k-way timestamp merge: queued stimulus, in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
	import kwm_pkg::*;

	// Sources actually usable, whatever the count register says.
	localparam int SRC_LIMIT = (MAX_SOURCES_DEF < SOURCE_SPAN) ? MAX_SOURCES_DEF : SOURCE_SPAN;
	localparam int ITEM_TARGET = 1150;
	// Cycles with no handshake of any kind before the run is declared hung.
	// Longest legal quiet stretch is a receiver hold plus a short pause.
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	// One input item, field for field as on the ports.
	typedef struct packed {
		logic [SRC_W-1:0]  src;
		logic [KEY_W-1:0]  ts;
		logic [DATA_W-1:0] payload;
		logic              end_mark;
	} merge_item_t;

	// One result item.
	typedef struct packed {
		logic [KEY_W-1:0]  ts;
		logic [SRC_W-1:0]  src;
		logic [DATA_W-1:0] payload;
		logic              last;
		logic              rejected;
	} merge_result_t;

	// Everything the merge remembers between items.
	typedef struct packed {
		logic [CNT_W-1:0]                      count_reg;
		logic [SOURCE_SPAN-1:0][KEY_W-1:0]  key;
		logic [SOURCE_SPAN-1:0][DATA_W-1:0] data;
		logic [SOURCE_SPAN-1:0]             full;
		logic [SOURCE_SPAN-1:0]             ended;
	} merge_state_t;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [SRC_W-1:0]  in_source     = '0;
	logic [KEY_W-1:0]  in_timestamp  = '0;
	logic [DATA_W-1:0] in_payload    = '0;
	logic              in_end        = 1'b0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [KEY_W-1:0]  out_timestamp;
	logic [SRC_W-1:0]  out_source;
	logic [DATA_W-1:0] out_payload;
	logic              out_last;
	logic              out_rejected;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data      = '0;

	kway_timestamp_merge DUT (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_source, .in_timestamp, .in_payload, .in_end,
		.out_valid, .out_stall, .out_timestamp, .out_source, .out_payload,
		.out_last, .out_rejected,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	// merge_plan runs ahead while the stimulus is built, so the generator knows
	// which source the block is waiting on. merge_now follows the items the
	// block really accepts and is the one the checks rely on.
	merge_state_t  merge_plan;
	merge_state_t  merge_now;
	merge_item_t   feed_queue[$];
	merge_result_t awaited_results[$];
	int            fed_count      = 0;
	int            accepted_count = 0;
	int            fault_count    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Zero acts as one source, anything past the limit as the limit.
	function automatic int live_sources(input logic [CNT_W-1:0] c);
		int n;
		n = int'(c);
		if (n == 0) n = 1;
		if (n > SRC_LIMIT) n = SRC_LIMIT;
		return n;
	endfunction

	// A count write abandons whatever merge is in flight.
	function automatic void restart_merge(inout merge_state_t st, input logic [CNT_W-1:0] v);
		st.count_reg = v;
		st.full = '0;
		st.ended = '0;
	endfunction

	// Applies one item; returns 1 when it yields a result.
	function automatic bit advance_merge(inout merge_state_t st, input merge_item_t it,
			output merge_result_t res);
		int n;
		int best;
		bit have;
		n = live_sources(st.count_reg);
		res = '0;
		best = 0;
		have = 1'b0;
		// out of range, slot taken, or source already closed: dropped
		if (int'(it.src) >= n || st.full[it.src] || st.ended[it.src]) begin
			res.rejected = 1'b1;
			return 1'b1;
		end
		if (it.end_mark) begin
			st.ended[it.src] = 1'b1;
		end else begin
			st.key[it.src] = it.ts;
			st.data[it.src] = it.payload;
			st.full[it.src] = 1'b1;
		end
		// strict less-than keeps ties on the lower source
		for (int i = 0; i < n; i++) begin
			if (!st.full[i] && !st.ended[i]) return 1'b0;
			if (st.full[i]) begin
				if (!have || st.key[i] < st.key[best]) best = i;
				have = 1'b1;
			end
		end
		if (!have) begin
			// all sources closed and drained: merge complete
			res.last = 1'b1;
			st.full = '0;
			st.ended = '0;
			return 1'b1;
		end
		st.full[best] = 1'b0;
		res.ts = st.key[best];
		res.src = SRC_W'(best);
		res.payload = st.data[best];
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic merge_item_t make_item(input logic [SRC_W-1:0] src, input logic end_mark,
			input logic [KEY_W-1:0] ts, input logic [DATA_W-1:0] payload);
		merge_item_t it;
		it.src = src;
		it.end_mark = end_mark;
		it.ts = ts;
		it.payload = payload;
		return it;
	endfunction

	// Queues an item and runs it through the look-ahead copy.
	// Returns 1 when the item completes the merge.
	function automatic bit feed(input merge_item_t it);
		merge_result_t r;
		bit got;
		got = advance_merge(merge_plan, it, r);
		feed_queue = {feed_queue, it};
		fed_count++;
		return got && r.last;
	endfunction

	// Everything queued is accepted and every expected result is out. Items
	// with no result may still sit in the pipe, so allow them time to drain.
	task automatic wait_idle();
		do @(posedge clk); while (accepted_count != fed_count || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		restart_merge(merge_now, v);
		restart_merge(merge_plan, v);
	endtask

	// One merge: per source a short sorted run of records then its end mark,
	// fed in the order the block asks for, with stray items mixed in.
	task automatic run_merge(input bit may_abandon);
		int n;
		int left_recs [SOURCE_SPAN];
		logic [KEY_W-1:0] next_key [SOURCE_SPAN];
		int key_mode;
		int pick;
		int start;
		int s;
		bit done;
		merge_item_t it;
		@(negedge clk);
		n = live_sources(merge_plan.count_reg);
		// narrow keys force ties, wide keys toggle every bit, top keys near overflow
		key_mode = $urandom_range(0, 2);
		for (int k = 0; k < SOURCE_SPAN; k++) begin
			left_recs[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
			case (key_mode)
				0: next_key[k] = KEY_W'($urandom_range(0, 20));
				1: next_key[k] = {$urandom, $urandom};
				default: next_key[k] = 64'hFFFF_FFFF_FFFF_FF00 + KEY_W'($urandom_range(0, 60));
			endcase
		end
		done = 1'b0;
		while (!done) begin
			// any source with an empty slot is one the block is waiting on
			pick = -1;
			start = $urandom_range(0, n - 1);
			for (int k = 0; k < n; k++) begin
				s = (start + k) % n;
				if (pick < 0 && !merge_plan.full[s] && !merge_plan.ended[s]) pick = s;
			end
			if (pick < 0 || $urandom_range(0, 11) == 0) begin
				// stray item: any source, may break the sequence
				it = make_item(SRC_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
					{$urandom, $urandom}, {$urandom, $urandom});
			end else if (left_recs[pick] == 0) begin
				// end mark; key and payload are don't-care
				it = make_item(SRC_W'(pick), 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
			end else begin
				it = make_item(SRC_W'(pick), 1'b0, next_key[pick], {$urandom, $urandom});
				left_recs[pick]--;
				next_key[pick] += KEY_W'($urandom_range(0, 3));
			end
			done = feed(it) || (may_abandon && $urandom_range(0, 30) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset, directed cases, then random merges
	// ------------------------------------------------------------------
	initial begin : sequencer
		int count_sweep [7] = '{1, 16, 31, 0, 17, 2, 8};
		int phase;
		logic [CNT_W-1:0] v;
		merge_now = '0;
		restart_merge(merge_now, CNT_W'(16));
		merge_plan = merge_now;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset count of 16: all sources active.
		@(negedge clk);
		void'(feed(make_item(4'd0, 1'b0, '1, '1)));          // largest key and payload
		void'(feed(make_item(4'd0, 1'b0, '0, '0)));          // slot already full
		void'(feed(make_item(4'd1, 1'b1, {$urandom, $urandom}, {$urandom, $urandom})));
		void'(feed(make_item(4'd1, 1'b1, '0, '0)));          // second end mark
		void'(feed(make_item(4'd1, 1'b0, '0, '0)));          // record after end
		// closing the rest releases the head of source 0
		for (int k = 2; k < SOURCE_SPAN; k++)
			void'(feed(make_item(SRC_W'(k), 1'b1, '0, '0)));
		void'(feed(make_item(4'd0, 1'b1, '0, '0)));          // completes the merge

		// Count zero behaves as one source.
		wait_idle();
		write_count(CNT_W'(0));
		@(negedge clk);
		void'(feed(make_item(4'd15, 1'b0, '1, '1)));         // source out of range
		void'(feed(make_item(4'd0, 1'b0, '0, '0)));          // smallest key, out at once
		void'(feed(make_item(4'd0, 1'b1, '0, '0)));

		// Equal keys: lower source wins; merge is then left hanging.
		wait_idle();
		write_count(CNT_W'(2));
		@(negedge clk);
		void'(feed(make_item(4'd1, 1'b0, 64'd5, {$urandom, $urandom})));
		void'(feed(make_item(4'd0, 1'b0, 64'd5, {$urandom, $urandom})));

		// Random merges; the first count write drops the hanging one.
		phase = 0;
		while (fed_count < ITEM_TARGET) begin
			v = (phase < 7) ? CNT_W'(count_sweep[phase]) : CNT_W'($urandom_range(0, 31));
			// sometimes go on without a write: the block clears itself on completion
			if (phase < 7 || $urandom_range(0, 3) != 0) begin
				wait_idle();
				write_count(v);
			end
			run_merge($urandom_range(0, 5) == 0);
			phase++;
		end

		wait_idle();
		repeat (6) @(posedge clk);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input driver: bursts of items separated by random gaps
	// ------------------------------------------------------------------
	int            burst_left = 0;
	int            gap_left   = 0;
	merge_item_t   taken;
	merge_item_t   upcoming;
	merge_result_t outcome;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_source <= '0;
			in_timestamp <= '0;
			in_payload <= '0;
			in_end <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				taken = make_item(in_source, in_end, in_timestamp, in_payload);
				if (advance_merge(merge_now, taken, outcome))
					awaited_results = {awaited_results, outcome};
				accepted_count++;
			end
			// payload only moves once the current item is gone
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || feed_queue.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					upcoming = feed_queue.pop_front();
					in_source <= upcoming.src;
					in_timestamp <= upcoming.ts;
					in_payload <= upcoming.payload;
					in_end <= upcoming.end_mark;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// a quarter of the bursts run straight into the next
						burst_left = $urandom_range(0, 39);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stall pattern: free, light and heavy stretches, plus two long
	// holds started while the driver is offering so the input backs up.
	// ------------------------------------------------------------------
	int stall_clock  = 0;
	int hold_left    = 0;
	int holds_done   = 0;
	int next_hold_at = 600;
	int seg_left     = 0;
	int stall_mode   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			stall_clock++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_done < 2 && stall_clock >= next_hold_at && in_valid) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				next_hold_at = stall_clock + 900;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(10, 80);
					stall_mode = $urandom_range(0, 2);
				end else begin
					seg_left--;
				end
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 6);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------
	merge_result_t want;

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result item with none expected: source %0d last %b rejected %b",
					out_source, out_last, out_rejected);
				fault_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("out_timestamp", want.ts, out_timestamp);
				check_field("out_source", 64'(want.src), 64'(out_source));
				check_field("out_payload", want.payload, out_payload);
				check_field("out_last", 64'(want.last), 64'(out_last));
				check_field("out_rejected", 64'(want.rejected), 64'(out_rejected));
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends a hung run
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// File: filelist.f
rtl/kwm_pkg.sv
rtl/kwm_slots.sv
rtl/kwm_min_tree.sv
rtl/kway_timestamp_merge.sv
bench/tb_top.sv
